@@ hw/rtl/vn_pkg.sv @@
// vn_pkg: shared constants and types for the vec3_normalize pipeline.
// No dependencies.
package vn_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int OUT_WIDTH     = 16;
  localparam int LANES         = 3;

  // control tag that rides along with each request
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [LANES-1:0] neg;
  } vn_tag_t;

endpackage

@@ hw/rtl/vec3_normalize.sv @@
// vec3_normalize: unit-length scaling of a signed 3-vector, Q1.FRAC_BITS out.
// Pipeline: 3 front stages, one stage per quotient bit, one output stage.
// Throughput one request per cycle while the output is not held.
// The whole pipeline stalls together while the output is held.
// Synchronous active-low reset clears all valid bits; data is not reset.
// Depends on vn_pkg, vn_front, vn_step.
module vec3_normalize import vn_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [IN_WIDTH-1:0]  in_comp_x,
  input  logic signed [IN_WIDTH-1:0]  in_comp_y,
  input  logic signed [IN_WIDTH-1:0]  in_comp_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] out_unit_x,
  output logic signed [OUT_WIDTH-1:0] out_unit_y,
  output logic signed [OUT_WIDTH-1:0] out_unit_z,
  output logic                        out_zero_input
);

  localparam int W  = IN_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = 2*W + 2*F + 5;
  localparam int BW = 2*W + F + 3;
  localparam int NS = F + 2;

  logic                 en;
  vn_tag_t              front_tag;
  logic [2*W-1:0]       front_sum;
  logic [2*W-2:0]       front_msq [LANES];

  vn_tag_t              tag_s [NS];
  logic [2*W-1:0]       sum_s [NS];
  logic [2*W-2:0]       msq_s [NS][LANES];
  logic [F:0]           q_s   [NS][LANES];
  logic signed [CW-1:0] a_s   [NS][LANES];
  logic signed [BW-1:0] b_s   [NS][LANES];

  vn_tag_t              out_tag_r;
  logic signed [OUT_WIDTH-1:0] unit_r [LANES];
  logic signed [OUT_WIDTH-1:0] unit_nxt [LANES];
  logic signed [F+1:0]  sq [LANES];

  assign en       = !out_tag_r.valid || out_ready;
  assign in_ready = en;

  vn_front #(.IN_WIDTH(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .comp_x   (in_comp_x),
    .comp_y   (in_comp_y),
    .comp_z   (in_comp_z),
    .tag_o    (front_tag),
    .sum_o    (front_sum),
    .msq_o    (front_msq)
  );

  // seed: q = 0, so 2q-1 = -1, A = s, B = -s
  assign tag_s[0] = front_tag;
  assign sum_s[0] = front_sum;
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      msq_s[0][i] = front_msq[i];
      q_s[0][i]   = '0;
      a_s[0][i]   = $signed({{(CW-2*W){1'b0}}, front_sum});
      b_s[0][i]   = -$signed({{(BW-2*W){1'b0}}, front_sum});
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < NS-1; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_s[k+1] <= '0;
      end else if (en) begin
        tag_s[k+1] <= tag_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sum_s[k+1] <= sum_s[k];
        msq_s[k+1] <= msq_s[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      vn_step #(.IN_WIDTH(W), .FRAC_BITS(F), .BIT(F-k)) u_step (
        .clk   (clk),
        .en    (en),
        .q_i   (q_s[k][l]),
        .a_i   (a_s[k][l]),
        .b_i   (b_s[k][l]),
        .sum_i (sum_s[k]),
        .msq_i (msq_s[k][l]),
        .q_o   (q_s[k+1][l]),
        .a_o   (a_s[k+1][l]),
        .b_o   (b_s[k+1][l])
      );
    end
  end

  // sign and zero-vector handling
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sq[i] = $signed({1'b0, q_s[NS-1][i]});
      if (tag_s[NS-1].neg[i]) sq[i] = -sq[i];
      unit_nxt[i] = tag_s[NS-1].zero ? '0 : OUT_WIDTH'(sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tag_r <= '0;
    end else if (en) begin
      out_tag_r <= tag_s[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
    end
  end

  assign out_valid      = out_tag_r.valid;
  assign out_zero_input = out_tag_r.zero;
  assign out_unit_x     = unit_r[0];
  assign out_unit_y     = unit_r[1];
  assign out_unit_z     = unit_r[2];

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_input |->
      out_unit_x == '0 && out_unit_y == '0 && out_unit_z == '0)
    else $error("zero vector gave nonzero components");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_unit_x) && $stable(out_zero_input))
    else $error("stalled pipeline changed output");
`endif

endmodule

@@ hw/rtl/vn_front.sv @@
// vn_front: magnitude, squares and sum of squares, three register stages.
// Depends on vn_pkg.
module vn_front import vn_pkg::*; #(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [IN_WIDTH-1:0] comp_x,
  input  logic signed [IN_WIDTH-1:0] comp_y,
  input  logic signed [IN_WIDTH-1:0] comp_z,
  output vn_tag_t                    tag_o,
  output logic [2*IN_WIDTH-1:0]      sum_o,
  output logic [2*IN_WIDTH-2:0]      msq_o [LANES]
);

  localparam int W = IN_WIDTH;

  vn_tag_t           tag_a_r, tag_b_r, tag_c_r;
  logic [W-1:0]      mag_r [LANES];
  logic [2*W-2:0]    sq_r  [LANES];
  logic [2*W-2:0]    msq_r [LANES];
  logic [2*W-1:0]    sum_r;
  logic [2*W-1:0]    sum_nxt;
  logic signed [W-1:0] comp [LANES];
  logic [W-1:0]      mag_nxt [LANES];
  logic [LANES-1:0]  neg_nxt;

  assign comp[0] = comp_x;
  assign comp[1] = comp_y;
  assign comp[2] = comp_z;

  // magnitude; most negative value maps to 2^(W-1), which fits W bits
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      neg_nxt[i] = comp[i][W-1];
      mag_nxt[i] = neg_nxt[i] ? (~comp[i] + W'(1)) : comp[i];
    end
  end

  assign sum_nxt = (2*W)'(sq_r[0]) + (2*W)'(sq_r[1]) + (2*W)'(sq_r[2]);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_c_r <= '0;
    end else if (en) begin
      tag_a_r <= '{valid: in_valid, zero: 1'b0, neg: neg_nxt};
      tag_b_r <= tag_a_r;
      tag_c_r <= '{valid: tag_b_r.valid, zero: (sum_nxt == '0), neg: tag_b_r.neg};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        mag_r[i] <= mag_nxt[i];
        sq_r[i]  <= (2*W-1)'(mag_r[i] * mag_r[i]);
        msq_r[i] <= sq_r[i];
      end
      sum_r <= sum_nxt;
    end
  end

  assign tag_o = tag_c_r;
  assign sum_o = sum_r;
  assign msq_o = msq_r;

endmodule

@@ hw/rtl/vn_step.sv @@
// vn_step: one quotient bit of round(m * 2^F / sqrt(s)) for one lane.
// Depends on vn_pkg. Keeps A = (2q-1)^2 * s and B = (2q-1) * s incrementally.
module vn_step import vn_pkg::*; #(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int BIT       = 0
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic [FRAC_BITS:0]                      q_i,
  input  logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] a_i,
  input  logic signed [2*IN_WIDTH+FRAC_BITS+2:0]  b_i,
  input  logic [2*IN_WIDTH-1:0]                   sum_i,
  input  logic [2*IN_WIDTH-2:0]                   msq_i,
  output logic [FRAC_BITS:0]                      q_o,
  output logic signed [2*IN_WIDTH+2*FRAC_BITS+4:0] a_o,
  output logic signed [2*IN_WIDTH+FRAC_BITS+2:0]  b_o
);

  localparam int W  = IN_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = 2*W + 2*F + 5;
  localparam int BW = 2*W + F + 3;

  logic signed [CW-1:0] cand;
  logic signed [CW-1:0] rhs;
  logic signed [CW-1:0] sum_ext;
  logic                 take;

  assign sum_ext = $signed({{(CW-2*W){1'b0}}, sum_i});
  // (2q-1+2^(b+1))^2 s = A + 2^(b+2) B + 2^(2b+2) s
  assign cand = a_i + (CW'(b_i) <<< (BIT+2)) + (sum_ext <<< (2*BIT+2));
  assign rhs  = $signed({{(CW-2*W-2*F-1){1'b0}}, msq_i, {(2*F+2){1'b0}}});
  // q already at the limit 2^F takes no further bits
  assign take = !q_i[F] && (cand <= rhs);

  always_ff @(posedge clk) begin
    if (en) begin
      q_o <= take ? (q_i | ((F+1)'(1) << BIT)) : q_i;
      a_o <= take ? cand : a_i;
      b_o <= take ? (b_i + (BW'(sum_ext) <<< (BIT+1))) : b_i;
    end
  end

endmodule
